// File: design/lfpd_pkg.sv
package lfpd_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BASE_DUTY      = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_FILTER_WEIGHT  = 3'd3,
    REG_SHARP_HOLD     = 3'd4,
    REG_LOST_STRAIGHT  = 3'd5,
    REG_MAX_DUTY       = 3'd6,
    REG_MIN_RUN_DUTY   = 3'd7
  } reg_idx_t;

  // Rule codes reported with each result word
  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_LOST_HOLD = 3'd1,
    ACT_SEARCH    = 3'd2,
    ACT_SHARP     = 3'd3,
    ACT_SHARP_END = 3'd4,
    ACT_NODE      = 3'd5,
    ACT_PD        = 3'd6
  } action_t;

  typedef struct packed {
    logic [6:0] base_duty;
    logic [5:0] prop_gain;
    logic [5:0] deriv_gain;
    logic [3:0] filter_weight;
    logic [7:0] sharp_hold_len;
    logic [7:0] lost_hold_len;
    logic [6:0] max_duty;
    logic [6:0] min_run_duty;
  } cfg_t;

  // Controller to datapath step strobes
  typedef struct packed {
    logic load;
    logic filt;
    logic diff;
    logic gain;
    logic commit;
  } lfpd_cmd_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [6:0] RST_BASE_DUTY     = 7'd62;
  localparam logic [5:0] RST_PROP_GAIN     = 6'd6;
  localparam logic [5:0] RST_DERIV_GAIN    = 6'd12;
  localparam logic [3:0] RST_FILTER_WEIGHT = 4'd6;
  localparam logic [7:0] RST_SHARP_HOLD    = 8'd90;
  localparam logic [7:0] RST_LOST_STRAIGHT = 8'd18;
  localparam logic [6:0] RST_MAX_DUTY      = 7'd92;
  localparam logic [6:0] RST_MIN_RUN_DUTY  = 7'd42;
  localparam logic [6:0] RST_COMMANDED     = 7'd62;

  localparam logic [15:0] LOST_CAP = 16'd60000;
  localparam logic [3:0]  FILT_FULL = 4'd10;

  // Fixed drive requests, signed to match the PD request width
  localparam logic signed [11:0] DUTY_START      = 12'sd85;
  localparam logic signed [11:0] DUTY_SHARP_OUT  = 12'sd90;
  localparam logic signed [11:0] DUTY_SHARP_IN   = 12'sd42;
  localparam logic signed [11:0] DUTY_NODE       = 12'sd70;
  localparam logic signed [11:0] DUTY_SEARCH_OUT = 12'sd85;
  localparam logic signed [11:0] DUTY_SEARCH_IN  = 12'sd30;

endpackage

// File: design/lfpd_cfg.sv
module lfpd_cfg
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_DUTY:     cfg_nxt.base_duty      = cfg_data[6:0];
        REG_PROP_GAIN:     cfg_nxt.prop_gain      = cfg_data[5:0];
        REG_DERIV_GAIN:    cfg_nxt.deriv_gain     = cfg_data[5:0];
        REG_FILTER_WEIGHT: cfg_nxt.filter_weight  = cfg_data[3:0];
        REG_SHARP_HOLD:    cfg_nxt.sharp_hold_len = cfg_data;
        REG_LOST_STRAIGHT: cfg_nxt.lost_hold_len  = cfg_data;
        REG_MAX_DUTY:      cfg_nxt.max_duty       = cfg_data[6:0];
        REG_MIN_RUN_DUTY:  cfg_nxt.min_run_duty   = cfg_data[6:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_duty      <= RST_BASE_DUTY;
      cfg_r.prop_gain      <= RST_PROP_GAIN;
      cfg_r.deriv_gain     <= RST_DERIV_GAIN;
      cfg_r.filter_weight  <= RST_FILTER_WEIGHT;
      cfg_r.sharp_hold_len <= RST_SHARP_HOLD;
      cfg_r.lost_hold_len  <= RST_LOST_STRAIGHT;
      cfg_r.max_duty       <= RST_MAX_DUTY;
      cfg_r.min_run_duty   <= RST_MIN_RUN_DUTY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/lfpd_ctrl.sv
module lfpd_ctrl
  import lfpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lfpd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILT  = 5'b00010,
    S_DIFF  = 5'b00100,
    S_GAIN  = 5'b01000,
    S_DRIVE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result slot can take a new word when empty or being drained now
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_DRIVE;
      end
      S_DRIVE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/lfpd_dp.sv
module lfpd_dp
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  lfpd_cmd_t  cmd,
  input  logic [4:0] in_sensor_mask,
  output logic [6:0] left_duty,
  output logic [6:0] right_duty,
  output logic [2:0] action
);

  // signed divide by ten, truncating toward zero; |n| < 8192
  function automatic logic signed [13:0] div10(logic signed [13:0] n);
    logic [12:0]        mag;
    logic [25:0]        prod;
    logic signed [13:0] qs;
    mag  = n[13] ? 13'(-n) : n[12:0];
    prod = {13'b0, mag} * 26'd6554;
    qs   = {4'b0, prod[25:16]};
    return n[13] ? -qs : qs;
  endfunction

  function automatic logic [6:0] clamp_duty(logic signed [11:0] v, logic [6:0] mx);
    logic signed [11:0] mx_s;
    mx_s = {5'b0, mx};
    if (v < 12'sd0) return 7'd0;
    else if (v > mx_s) return mx;
    else return v[6:0];
  endfunction

  // item payload and pipeline registers
  logic [4:0]         mask_r;
  logic signed [10:0] num_r;
  logic signed [6:0]  fe_new_r;
  logic signed [7:0]  derr_r;
  logic signed [13:0] sum_r;

  // control state
  logic               start_r, start_nxt;
  logic [15:0]        lost_r, lost_nxt;
  logic [7:0]         sharp_r, sharp_nxt;
  logic               sharp_right_r, sharp_right_nxt;
  logic signed [6:0]  fe_r, fe_nxt;
  logic signed [6:0]  prev_r, prev_nxt;
  logic [6:0]         cmd_l_r, cmd_l_nxt, cmd_r_r, cmd_r_nxt;
  logic [6:0]         app_l_r, app_l_nxt, app_r_r, app_r_nxt;
  action_t            act_r, act_nxt;

  // mask decode
  logic [2:0]         cnt;
  logic signed [7:0]  wsum;
  logic signed [6:0]  pos_err;

  assign cnt = {2'b0, mask_r[0]} + {2'b0, mask_r[1]} + {2'b0, mask_r[2]}
             + {2'b0, mask_r[3]} + {2'b0, mask_r[4]};

  always_comb begin
    wsum = 8'sd0;
    if (mask_r[0]) wsum = wsum + 8'sd40;
    if (mask_r[1]) wsum = wsum + 8'sd20;
    if (mask_r[3]) wsum = wsum - 8'sd20;
    if (mask_r[4]) wsum = wsum - 8'sd40;
  end

  // weighted mean; only one to three sensors reach the PD rule
  always_comb begin
    pos_err = 7'sd0;
    case (cnt)
      3'd1: pos_err = wsum[6:0];
      3'd2: pos_err = 7'(wsum >>> 1);
      3'd3: begin
        case (wsum)
          8'sd60:  pos_err = 7'sd20;
          8'sd40:  pos_err = 7'sd13;
          8'sd20:  pos_err = 7'sd6;
          -8'sd20: pos_err = -7'sd6;
          -8'sd40: pos_err = -7'sd13;
          -8'sd60: pos_err = -7'sd20;
          default: pos_err = 7'sd0;
        endcase
      end
      default: pos_err = 7'sd0;
    endcase
  end

  // step 1: low-pass numerator
  logic [3:0]         w_c;
  logic signed [10:0] w_s, wc_s, fe_x, err_x, num;

  assign w_c   = (cfg.filter_weight > FILT_FULL) ? FILT_FULL : cfg.filter_weight;
  assign w_s   = {7'b0, w_c};
  assign wc_s  = {7'b0, FILT_FULL - w_c};
  assign fe_x  = {{4{fe_r[6]}}, fe_r};
  assign err_x = {{4{pos_err[6]}}, pos_err};
  assign num   = fe_x * w_s + err_x * wc_s;

  // step 2: filtered error and its change
  logic signed [13:0] fe_div;
  logic signed [6:0]  fe_new;
  logic signed [7:0]  derr;

  assign fe_div = div10({{3{num_r[10]}}, num_r});
  assign fe_new = fe_div[6:0];
  assign derr   = {fe_new[6], fe_new} - {prev_r[6], prev_r};

  // step 3: PD products
  logic signed [13:0] p_s, d_s, fe_w, derr_w, pd_sum;

  assign p_s    = {8'b0, cfg.prop_gain};
  assign d_s    = {8'b0, cfg.deriv_gain};
  assign fe_w   = {{7{fe_new_r[6]}}, fe_new_r};
  assign derr_w = {{6{derr_r[7]}}, derr_r};
  assign pd_sum = p_s * fe_w + d_s * derr_w;

  // step 4: turn, rule selection and drive
  logic signed [13:0] turn;
  logic signed [11:0] base_s, drv_l, drv_r;
  logic               drv_en, hold_en;
  logic [15:0]        lost_inc;
  logic [6:0]         cl_l, cl_r, fl_l, fl_r;

  assign turn     = div10(sum_r);
  assign base_s   = {5'b0, cfg.base_duty};
  assign lost_inc = (lost_r < LOST_CAP) ? lost_r + 16'd1 : lost_r;

  always_comb begin
    start_nxt       = start_r;
    lost_nxt        = lost_r;
    sharp_nxt       = sharp_r;
    sharp_right_nxt = sharp_right_r;
    fe_nxt          = fe_r;
    prev_nxt        = prev_r;
    act_nxt         = ACT_PD;
    drv_en          = 1'b0;
    hold_en         = 1'b0;
    drv_l           = 12'sd0;
    drv_r           = 12'sd0;
    if (start_r && cnt == 3'd5) begin
      act_nxt = ACT_START;
      drv_en  = 1'b1;
      drv_l   = DUTY_START;
      drv_r   = DUTY_START;
    end else begin
      start_nxt = 1'b0;
      if (cnt == 3'd0) begin
        lost_nxt = lost_inc;
        if (lost_inc <= {8'b0, cfg.lost_hold_len}) begin
          act_nxt = ACT_LOST_HOLD;
          if (cmd_l_r == 7'd0 && cmd_r_r == 7'd0) begin
            drv_en = 1'b1;
            drv_l  = base_s;
            drv_r  = base_s;
          end else begin
            hold_en = 1'b1;
          end
        end else begin
          act_nxt = ACT_SEARCH;
          drv_en  = 1'b1;
          // search toward the side of the last error
          drv_l   = prev_r[6] ? DUTY_SEARCH_IN : DUTY_SEARCH_OUT;
          drv_r   = prev_r[6] ? DUTY_SEARCH_OUT : DUTY_SEARCH_IN;
        end
      end else begin
        lost_nxt = 16'd0;
        if (sharp_r != 8'd0) begin
          sharp_nxt = sharp_r - 8'd1;
          if (mask_r[2]) begin
            // center seen: latch ends, outputs repeat last applied duties
            sharp_nxt = 8'd0;
            prev_nxt  = 7'sd0;
            act_nxt   = ACT_SHARP_END;
          end else begin
            act_nxt = ACT_SHARP;
            drv_en  = 1'b1;
            drv_l   = sharp_right_r ? DUTY_SHARP_OUT : DUTY_SHARP_IN;
            drv_r   = sharp_right_r ? DUTY_SHARP_IN : DUTY_SHARP_OUT;
          end
        end else if (cnt >= 3'd4) begin
          prev_nxt = 7'sd0;
          act_nxt  = ACT_NODE;
          drv_en   = 1'b1;
          drv_l    = DUTY_NODE;
          drv_r    = DUTY_NODE;
        end else if (mask_r[0] && !mask_r[3]) begin
          sharp_right_nxt = 1'b1;
          sharp_nxt       = cfg.sharp_hold_len;
          act_nxt         = ACT_SHARP;
          drv_en          = 1'b1;
          drv_l           = DUTY_SHARP_OUT;
          drv_r           = DUTY_SHARP_IN;
        end else if (mask_r[4] && !mask_r[1]) begin
          sharp_right_nxt = 1'b0;
          sharp_nxt       = cfg.sharp_hold_len;
          act_nxt         = ACT_SHARP;
          drv_en          = 1'b1;
          drv_l           = DUTY_SHARP_IN;
          drv_r           = DUTY_SHARP_OUT;
        end else begin
          fe_nxt   = fe_new_r;
          prev_nxt = fe_new_r;
          act_nxt  = ACT_PD;
          drv_en   = 1'b1;
          drv_l    = base_s + turn[11:0];
          drv_r    = base_s - turn[11:0];
        end
      end
    end
  end

  // clamp, then floor at the running minimum, then clamp the applied value
  assign cl_l = clamp_duty(drv_l, cfg.max_duty);
  assign cl_r = clamp_duty(drv_r, cfg.max_duty);
  assign fl_l = (cl_l < cfg.min_run_duty) ? cfg.min_run_duty : cl_l;
  assign fl_r = (cl_r < cfg.min_run_duty) ? cfg.min_run_duty : cl_r;

  always_comb begin
    cmd_l_nxt = cmd_l_r;
    cmd_r_nxt = cmd_r_r;
    app_l_nxt = app_l_r;
    app_r_nxt = app_r_r;
    if (drv_en) begin
      if (drv_l == 12'sd0 && drv_r == 12'sd0) begin
        cmd_l_nxt = 7'd0;
        cmd_r_nxt = 7'd0;
        app_l_nxt = 7'd0;
        app_r_nxt = 7'd0;
      end else begin
        cmd_l_nxt = fl_l;
        cmd_r_nxt = fl_r;
        app_l_nxt = (fl_l > cfg.max_duty) ? cfg.max_duty : fl_l;
        app_r_nxt = (fl_r > cfg.max_duty) ? cfg.max_duty : fl_r;
      end
    end else if (hold_en) begin
      app_l_nxt = (cmd_l_r > cfg.max_duty) ? cfg.max_duty : cmd_l_r;
      app_r_nxt = (cmd_r_r > cfg.max_duty) ? cfg.max_duty : cmd_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mask_r <= in_sensor_mask;
    if (cmd.filt) num_r <= num;
    if (cmd.diff) begin
      fe_new_r <= fe_new;
      derr_r   <= derr;
    end
    if (cmd.gain) sum_r <= pd_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 1'b1;
      lost_r        <= 16'd0;
      sharp_r       <= 8'd0;
      sharp_right_r <= 1'b0;
      fe_r          <= 7'sd0;
      prev_r        <= 7'sd0;
      cmd_l_r       <= RST_COMMANDED;
      cmd_r_r       <= RST_COMMANDED;
      app_l_r       <= 7'd0;
      app_r_r       <= 7'd0;
      act_r         <= ACT_START;
    end else if (cmd.commit) begin
      start_r       <= start_nxt;
      lost_r        <= lost_nxt;
      sharp_r       <= sharp_nxt;
      sharp_right_r <= sharp_right_nxt;
      fe_r          <= fe_nxt;
      prev_r        <= prev_nxt;
      cmd_l_r       <= cmd_l_nxt;
      cmd_r_r       <= cmd_r_nxt;
      app_l_r       <= app_l_nxt;
      app_r_r       <= app_r_nxt;
      act_r         <= act_nxt;
    end
  end

  // applied duties change only at commit, so they double as the result word
  assign left_duty  = app_l_r;
  assign right_duty = app_r_r;
  assign action     = act_r;

endmodule

// File: design/line_follow_pd_steering_core.sv
// Line follower PD steering core: one sensor word in, one duty word out.
// The accepted word steps through the filter numerator, filtered error,
// PD products, and divide and drive; out_valid is registered from the commit.
// A new word is accepted only when idle, after the four-step shared datapath
// sequence has committed the last one; a stalled result holds the drive step.
// Reset: rst_n synchronous active low; control and tuning registers reset, start phase set.
module line_follow_pd_steering_core
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // sensor words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [4:0]            in_sensor_mask,
  // duty words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_left_duty,
  output logic [6:0]            out_right_duty,
  output logic [2:0]            out_action,
  // register writes, taken at any time, meant only while idle
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  lfpd_cmd_t cmd;

  // register file for the eight tuning registers
  lfpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: accept, step the datapath, hand the word to the output slot
  lfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: mask decode, low-pass filter, PD law, rule select, duty clamp.
  // Its applied-duty registers are the output slot; they update only when
  // the slot is empty or being drained, so a new word can be accepted while
  // the previous result still waits.
  lfpd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .in_sensor_mask (in_sensor_mask),
    .left_duty      (out_left_duty),
    .right_duty     (out_right_duty),
    .action         (out_action)
  );

endmodule
